// ===== hdl/ckvt_pkg.sv =====
// ----------------------------------------------------------------------------
// ckvt_pkg
// Shared types and constants of the compacting key/value table.
// ----------------------------------------------------------------------------
package ckvt_pkg;

    localparam int KEY_W   = 8;
    localparam int VALUE_W = 16;
    localparam int POS_W   = 3;
    localparam int COUNT_W = 4;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        op_t                op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic               shift;
    } cell_cmd_t;

    typedef struct packed {
        logic hit;
        logic hit_empty;
        logic pass;
    } cell_stat_t;

endpackage

// ===== hdl/ckvt_cell.sv =====
// ----------------------------------------------------------------------------
// ckvt_cell
// One table slot: holds a key/value pair, checks it when the scan token
// arrives, and takes its upper neighbor's pair while a removal compacts.
// ----------------------------------------------------------------------------
module ckvt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      token,
    input  ckvt_pkg::cell_cmd_t       cmd,
    input  logic [ckvt_pkg::KEY_W-1:0]   next_key,
    input  logic [ckvt_pkg::VALUE_W-1:0] next_value,
    output logic [ckvt_pkg::KEY_W-1:0]   key,
    output logic [ckvt_pkg::VALUE_W-1:0] value,
    output ckvt_pkg::cell_stat_t      stat
);
    import ckvt_pkg::*;

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               is_add;
    logic               is_rem;
    logic               match_add;
    logic               match_rem;
    logic               hit;

    always_comb
    begin
        is_add    = (cmd.op == OP_ADD);
        is_rem    = (cmd.op == OP_REMOVE);
        match_add = (key_reg == cmd.key) || (key_reg == '0);
        match_rem = (key_reg == cmd.key);
        hit       = token && !cmd.shift
                    && ((is_add && match_add) || (is_rem && match_rem));

        stat.hit       = hit;
        stat.hit_empty = hit && (key_reg == '0);
        stat.pass      = token && !(is_add && hit);

        key_next   = key_reg;
        value_next = value_reg;
        if (clear)
        begin
            key_next   = '0;
            value_next = '0;
        end
        else if (token && is_rem && (cmd.shift || hit))
        begin
            key_next   = next_key;
            value_next = next_value;
        end
        else if (is_add && hit)
        begin
            key_next   = cmd.key;
            value_next = cmd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            value_reg <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            value_reg <= value_next;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

// ===== hdl/compacting_key_value_table.sv =====
// ----------------------------------------------------------------------------
// compacting_key_value_table
// Compacting key/value table built as a row of slot cells.
// ----------------------------------------------------------------------------
// Takes one item at a time and returns one result item for each. Used
// entries sit at the front of the table; key 0 marks an empty slot. Add and
// remove send a token up the row of cells, one slot per clock: add stops at
// the first slot that holds its key or is empty (or at the end of the row if
// the table is full), and remove always runs through the whole row since the
// later slots shift down behind the token. Read and clear need no scan. A
// finished result waits in the output register while the next item is
// accepted and worked on.
module compacting_key_value_table #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op[1:0], key[9:2], value[25:10], position[28:26], zero pad
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], used_count[4:1], read_key[12:5], read_value[28:13], zero pad
    output logic [31:0] m_axis_tdata
);
    import ckvt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    state_t             state_reg;
    state_t             state_next;
    op_t                op_reg;
    op_t                op_next;
    logic [KEY_W-1:0]   cmd_key_reg;
    logic [KEY_W-1:0]   cmd_key_next;
    logic [VALUE_W-1:0] cmd_value_reg;
    logic [VALUE_W-1:0] cmd_value_next;
    logic               shift_reg;
    logic               shift_next;
    logic [TABLE_DEPTH-1:0] token_reg;
    logic [TABLE_DEPTH-1:0] token_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               res_ok_reg;
    logic               res_ok_next;
    logic [KEY_W-1:0]   res_key_reg;
    logic [KEY_W-1:0]   res_key_next;
    logic [VALUE_W-1:0] res_value_reg;
    logic [VALUE_W-1:0] res_value_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;

    logic               in_accept;
    op_t                in_op;
    logic [KEY_W-1:0]   in_key;
    logic [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]   in_position;
    logic               clear_all;
    cell_cmd_t          cmd;

    logic [KEY_W-1:0]   cell_key   [TABLE_DEPTH];
    logic [VALUE_W-1:0] cell_value [TABLE_DEPTH];
    cell_stat_t         cell_stat  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] hit_empty_vec;
    logic [TABLE_DEPTH-1:0] pass_vec;
    logic               hit_any;
    logic               hit_empty_any;

    logic               rd_ok;
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    logic [COUNT_W-1:0] used_sat;
    logic               rem_ok;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = op_t'(s_axis_tdata[1:0]);
    assign in_key        = s_axis_tdata[9:2];
    assign in_value      = s_axis_tdata[25:10];
    assign in_position   = s_axis_tdata[28:26];
    assign clear_all     = in_accept && (in_op == OP_CLEAR);

    assign cmd.op    = op_reg;
    assign cmd.key   = cmd_key_reg;
    assign cmd.value = cmd_value_reg;
    assign cmd.shift = shift_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0]   nb_key;
        logic [VALUE_W-1:0] nb_value;

        if (i == TABLE_DEPTH - 1)
        begin : g_last
            assign nb_key   = '0;
            assign nb_value = '0;
        end
        else
        begin : g_mid
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end

        ckvt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .clear      (clear_all),
            .token      (token_reg[i]),
            .cmd        (cmd),
            .next_key   (nb_key),
            .next_value (nb_value),
            .key        (cell_key[i]),
            .value      (cell_value[i]),
            .stat       (cell_stat[i])
        );

        assign hit_vec[i]       = cell_stat[i].hit;
        assign hit_empty_vec[i] = cell_stat[i].hit_empty;
        assign pass_vec[i]      = cell_stat[i].pass;
    end

    assign hit_any       = |hit_vec;
    assign hit_empty_any = |hit_empty_vec;
    assign rem_ok        = shift_reg || hit_any;

    always_comb
    begin
        rd_ok    = (32'(in_position) < TABLE_DEPTH);
        rd_key   = '0;
        rd_value = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (32'(in_position) == i)
            begin
                rd_key   = cell_key[i];
                rd_value = cell_value[i];
            end
        end
    end

    assign used_sat = (32'(count_reg) > 32'd15) ? 4'd15 : COUNT_W'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        cmd_key_next   = cmd_key_reg;
        cmd_value_next = cmd_value_reg;
        shift_next     = shift_reg;
        token_next     = '0;
        count_next     = count_reg;
        res_ok_next    = res_ok_reg;
        res_key_next   = res_key_reg;
        res_value_next = res_value_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next        = in_op;
                    cmd_key_next   = in_key;
                    cmd_value_next = in_value;
                    shift_next     = 1'b0;
                    res_key_next   = '0;
                    res_value_next = '0;
                    unique case (in_op)
                        OP_ADD, OP_REMOVE:
                        begin
                            token_next[0] = 1'b1;
                            state_next    = ST_SCAN;
                        end
                        OP_READ:
                        begin
                            res_ok_next    = rd_ok;
                            res_key_next   = rd_ok ? rd_key : '0;
                            res_value_next = rd_ok ? rd_value : '0;
                            state_next     = ST_RESULT;
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            res_ok_next = 1'b1;
                            state_next  = ST_RESULT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                token_next = {pass_vec[TABLE_DEPTH-2:0], 1'b0};
                shift_next = shift_reg || hit_any;
                if (op_reg == OP_ADD)
                begin
                    if (hit_any)
                    begin
                        res_ok_next = 1'b1;
                        if (hit_empty_any && (cmd_key_reg != '0))
                        begin
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_RESULT;
                    end
                    else if (pass_vec[TABLE_DEPTH-1])
                    begin
                        res_ok_next = 1'b0;
                        state_next  = ST_RESULT;
                    end
                end
                else if (pass_vec[TABLE_DEPTH-1])
                begin
                    res_ok_next = rem_ok;
                    if (rem_ok && (cmd_key_reg != '0))
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, res_value_reg, res_key_reg, used_sat,
                                      res_ok_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            shift_reg     <= 1'b0;
            token_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            shift_reg     <= shift_next;
            token_reg     <= token_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        cmd_key_reg   <= cmd_key_next;
        cmd_value_reg <= cmd_value_next;
        res_ok_reg    <= res_ok_next;
        res_key_reg   <= res_key_next;
        res_value_reg <= res_value_next;
        out_data_reg  <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTH
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(token_reg))
        else $error("more than one scan token in the row");

    a_token_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (token_reg == '0))
        else $error("scan token outside of a scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TABLE_DEPTH)
        else $error("entry count beyond table depth");

    a_result_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("pending result item dropped");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compacting key/value table.
// ----------------------------------------------------------------------------
// Drives add, remove, read and clear items into the slave stream and keeps a
// shadow copy of the slots. Every accepted item updates the shadow and queues
// the reply it should produce. Each reply on the master stream is checked
// field by field against the oldest queued one. Both streams idle in random
// bursts, except in the final back-to-back part of the run.
// ----------------------------------------------------------------------------
module tb_top;

    import ckvt_pkg::*;

    localparam int TABLE_DEPTH    = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] used_count;
        logic [KEY_W-1:0]   read_key;
        logic [VALUE_W-1:0] read_value;
    } slot_reply_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;

    logic [KEY_W-1:0]   slot_keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] slot_values [TABLE_DEPTH];
    slot_reply_t        slot_replies[$];

    bit tx_idle      = 1'b1;
    bit rx_idle      = 1'b1;
    int rx_hold      = 0;
    int stall_cycles = 0;
    int fail_count   = 0;

    compacting_key_value_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [COUNT_W-1:0] count_leading_used();
        int n;
        n = 0;
        while (n < TABLE_DEPTH && slot_keys[n] != '0)
            n++;
        if (n > 15)
            n = 15;
        return n[COUNT_W-1:0];
    endfunction

    function automatic slot_reply_t apply_slot_op(op_t op, logic [KEY_W-1:0] key,
                                                  logic [VALUE_W-1:0] value,
                                                  logic [POS_W-1:0] position);
        slot_reply_t reply;
        int          hit;
        reply = '0;
        hit   = -1;
        case (op)
            OP_ADD:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && (slot_keys[i] == key || slot_keys[i] == '0))
                        hit = i;
                if (hit >= 0)
                begin
                    slot_keys[hit]   = key;
                    slot_values[hit] = value;
                    reply.ok         = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                    if (hit < 0 && slot_keys[i] == key)
                        hit = i;
                if (hit >= 0)
                begin
                    for (int i = hit + 1; i < TABLE_DEPTH; i++)
                    begin
                        slot_keys[i-1]   = slot_keys[i];
                        slot_values[i-1] = slot_values[i];
                    end
                    slot_keys[TABLE_DEPTH-1]   = '0;
                    slot_values[TABLE_DEPTH-1] = '0;
                    reply.ok                   = 1'b1;
                end
            end
            OP_READ:
            begin
                if (int'(position) < TABLE_DEPTH)
                begin
                    reply.read_key   = slot_keys[position];
                    reply.read_value = slot_values[position];
                    reply.ok         = 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < TABLE_DEPTH; i++)
                begin
                    slot_keys[i]   = '0;
                    slot_values[i] = '0;
                end
                reply.ok = 1'b1;
            end
        endcase
        reply.used_count = count_leading_used();
        return reply;
    endfunction

    task automatic send_item(op_t op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value,
                             logic [POS_W-1:0] position);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, position, value, key, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        slot_replies.push_back(apply_slot_op(op, key, value, position));
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (slot_replies.size() != 0);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        else if (roll < 75)
            return KEY_W'($urandom_range(1, 12));
        else
            return KEY_W'($urandom_range(0, 255));
    endfunction

    function automatic op_t pick_op();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return OP_ADD;
        else if (roll < 65)
            return OP_REMOVE;
        else if (roll < 95)
            return OP_READ;
        else
            return OP_CLEAR;
    endfunction

    task automatic test_directed();
        send_item(OP_READ, 8'd0, 16'h0000, 3'd0);
        send_item(OP_READ, 8'd0, 16'h0000, 3'd7);
        send_item(OP_ADD, 8'hff, 16'hffff, 3'd0);
        send_item(OP_ADD, 8'h01, 16'h0000, 3'd7);
        send_item(OP_ADD, 8'hff, 16'h5a5a, 3'd0);
        // zero key lands in the first empty slot and leaves it empty
        send_item(OP_ADD, 8'h00, 16'h1234, 3'd0);
        send_item(OP_READ, 8'd0, 16'h0000, 3'd2);
        for (int k = 2; k < 8; k++)
            send_item(OP_ADD, KEY_W'(k), VALUE_W'(16'h1111 * k), 3'(k));
        send_item(OP_ADD, 8'h09, 16'hbeef, 3'd0);
        send_item(OP_ADD, 8'h00, 16'hffff, 3'd0);
        send_item(OP_ADD, 8'h07, 16'hcafe, 3'd0);
        send_item(OP_REMOVE, 8'h00, 16'h0000, 3'd0);
        send_item(OP_REMOVE, 8'd100, 16'h0000, 3'd0);
        send_item(OP_REMOVE, 8'hff, 16'h0000, 3'd0);
        send_item(OP_REMOVE, 8'h00, 16'h0000, 3'd0);
        send_item(OP_READ, 8'd0, 16'h0000, 3'd7);
        send_item(OP_CLEAR, 8'hff, 16'hffff, 3'd7);
        send_item(OP_READ, 8'd0, 16'h0000, 3'd3);
    endtask

    task automatic test_random_mix(int count);
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_until_drained();
            send_item(pick_op(), pick_key(), VALUE_W'($urandom()), POS_W'($urandom()));
        end
    endtask

    task automatic test_fill_and_drain(int rounds);
        logic [KEY_W-1:0] keys[TABLE_DEPTH];
        logic [KEY_W-1:0] swap;
        int               j;
        bit               taken;
        for (int r = 0; r < rounds; r++)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                do
                begin
                    keys[i] = KEY_W'($urandom_range(1, 255));
                    taken   = 1'b0;
                    for (int k = 0; k < i; k++)
                        if (keys[k] == keys[i])
                            taken = 1'b1;
                end
                while (taken);
            end
            send_item(OP_CLEAR, KEY_W'($urandom()), VALUE_W'($urandom()), POS_W'($urandom()));
            for (int i = 0; i < TABLE_DEPTH; i++)
                send_item(OP_ADD, keys[i], VALUE_W'($urandom()), POS_W'($urandom()));
            send_item(OP_ADD, KEY_W'($urandom_range(1, 255)), VALUE_W'($urandom()), 3'd0);
            send_item(OP_ADD, 8'h00, VALUE_W'($urandom()), 3'd0);
            for (int i = 0; i < TABLE_DEPTH; i++)
                send_item(OP_READ, KEY_W'($urandom()), VALUE_W'($urandom()), POS_W'(i));
            for (int i = TABLE_DEPTH - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                swap    = keys[i];
                keys[i] = keys[j];
                keys[j] = swap;
            end
            for (int i = 0; i < TABLE_DEPTH; i++)
                send_item(OP_REMOVE, keys[i], VALUE_W'($urandom()), POS_W'($urandom()));
            send_item(OP_REMOVE, keys[0], 16'h0000, 3'd0);
        end
    endtask

    task automatic test_back_to_back(int count);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (int n = 0; n < count; n++)
            send_item(pick_op(), pick_key(), VALUE_W'($urandom()), POS_W'($urandom()));
    endtask

    task automatic compare_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expected, actual);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        slot_reply_t got;
        slot_reply_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.ok         = m_axis_tdata[0];
            got.used_count = m_axis_tdata[4:1];
            got.read_key   = m_axis_tdata[12:5];
            got.read_value = m_axis_tdata[28:13];
            if (slot_replies.size() == 0)
            begin
                $display("%0t ns: unexpected item, actual 0x%0h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = slot_replies.pop_front();
                compare_field("ok", want.ok, got.ok);
                compare_field("used_count", want.used_count, got.used_count);
                compare_field("read_key", want.read_key, got.read_key);
                compare_field("read_value", want.read_value, got.read_value);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end
        else if (rx_idle && $urandom_range(0, 7) == 0)
        begin
            rx_hold = $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            slot_keys[i]   = '0;
            slot_values[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_mix(1200);
        test_fill_and_drain(10);
        test_back_to_back(320);
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
